### src/websocket_frame_deframer_defines.svh
// Assertion macros used by the deframer parser RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer next-cycle check failed");

`endif

### src/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

    localparam logic [7:0] CLOSE_BYTE  = 8'h88;
    localparam logic [7:0] FIN_MASK    = 8'h80;
    localparam logic [7:0] OPCODE_MASK = 8'h0f;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_CLOSE    = 3'd1,
        KIND_BADOP    = 3'd2,
        KIND_UNMASKED = 3'd3,
        KIND_EXTLEN   = 3'd4,
        KIND_EMPTY    = 3'd5
    } kind_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload;
        logic       last;
    } result_t;

endpackage

### src/wsd_in_stage.sv
// Input register stage: holds one received byte until the parser takes it.
module wsd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Accept a new byte when empty or when the held byte leaves this cycle.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

### src/wsd_parser.sv
// Frame parser: header checks, mask gathering and payload unmasking.
`include "websocket_frame_deframer_defines.svh"

module wsd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    input  logic              advance,
    output wsd_pkg::result_t  res
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_MASK,
        PH_DATA,
        PH_STOP
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] mask_key_reg;
    logic [31:0] mask_key_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [6:0]  remain_reg;
    logic [6:0]  remain_next;
    logic [7:0]  mask_byte;
    logic [6:0]  remain_dec;

    always_comb
    begin
        case (pos_reg)
            2'd0:    mask_byte = mask_key_reg[31:24];
            2'd1:    mask_byte = mask_key_reg[23:16];
            2'd2:    mask_byte = mask_key_reg[15:8];
            default: mask_byte = mask_key_reg[7:0];
        endcase
    end

    assign remain_dec = remain_reg - 7'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        mask_key_next = mask_key_reg;
        pos_next      = pos_reg;
        remain_next   = remain_reg;
        res.valid     = 1'b0;
        res.kind      = wsd_pkg::KIND_DATA;
        res.payload   = 8'd0;
        res.last      = 1'b0;
        case (phase_reg)
            PH_HDR0:
            begin
                if (byte_data == wsd_pkg::CLOSE_BYTE)
                begin
                    phase_next = PH_STOP;
                    res.valid  = byte_valid;
                    res.kind   = wsd_pkg::KIND_CLOSE;
                end
                else if ((byte_data & wsd_pkg::FIN_MASK) == 8'd0
                         || (byte_data & wsd_pkg::OPCODE_MASK) == 8'd0)
                begin
                    phase_next = PH_STOP;
                    res.valid  = byte_valid;
                    res.kind   = wsd_pkg::KIND_BADOP;
                end
                else
                begin
                    phase_next = PH_HDR1;
                end
            end
            PH_HDR1:
            begin
                if ((byte_data & wsd_pkg::MASK_BIT) == 8'd0)
                begin
                    phase_next = PH_STOP;
                    res.valid  = byte_valid;
                    res.kind   = wsd_pkg::KIND_UNMASKED;
                end
                else if (byte_data[6:0] == wsd_pkg::LEN_EXT16
                         || byte_data[6:0] == wsd_pkg::LEN_EXT64)
                begin
                    phase_next = PH_STOP;
                    res.valid  = byte_valid;
                    res.kind   = wsd_pkg::KIND_EXTLEN;
                end
                else
                begin
                    remain_next   = byte_data[6:0];
                    pos_next      = 2'd0;
                    mask_key_next = 32'd0;
                    phase_next    = PH_MASK;
                end
            end
            PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], byte_data};
                pos_next      = pos_reg + 2'd1;
                // The fourth key byte closes the key; an empty frame ends here.
                if (pos_reg == 2'd3)
                begin
                    if (remain_reg == 7'd0)
                    begin
                        phase_next = PH_HDR0;
                        res.valid  = byte_valid;
                        res.kind   = wsd_pkg::KIND_EMPTY;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                pos_next    = pos_reg + 2'd1;
                remain_next = remain_dec;
                res.valid   = byte_valid;
                res.kind    = wsd_pkg::KIND_DATA;
                res.payload = byte_data ^ mask_byte;
                if (remain_dec == 7'd0)
                begin
                    res.last   = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            mask_key_reg <= 32'd0;
            pos_reg      <= 2'd0;
            remain_reg   <= 7'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            mask_key_reg <= mask_key_next;
            pos_reg      <= pos_next;
            remain_reg   <= remain_next;
        end
    end

    `WSD_ASSERT_SAME(a_side_fields_zero, clk, rst_n,
        res.valid && res.kind != wsd_pkg::KIND_DATA, res.payload == 8'd0 && !res.last)
    `WSD_ASSERT_SAME(a_last_only_data, clk, rst_n,
        res.last, res.kind == wsd_pkg::KIND_DATA && phase_reg == PH_DATA)
    `WSD_ASSERT_NEXT(a_stop_sticky, clk, rst_n,
        phase_reg == PH_STOP, phase_reg == PH_STOP)
    `WSD_ASSERT_NEXT(a_fault_stops, clk, rst_n,
        advance && res.valid && (res.kind == wsd_pkg::KIND_CLOSE
            || res.kind == wsd_pkg::KIND_BADOP || res.kind == wsd_pkg::KIND_UNMASKED
            || res.kind == wsd_pkg::KIND_EXTLEN), phase_reg == PH_STOP)

endmodule

### src/wsd_out_stage.sv
// Output register stage: holds one result until the consumer takes it.
module wsd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  wsd_pkg::result_t res,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       kind,
    output logic [7:0]       payload_byte,
    output logic             last_byte
);

    logic             valid_reg;
    logic             valid_next;
    wsd_pkg::kind_t   kind_reg;
    logic [7:0]       payload_reg;
    logic             last_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res.valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            kind_reg    <= res.kind;
            payload_reg <= res.payload;
            last_reg    <= res.last;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = 3'(kind_reg);
    assign payload_byte = payload_reg;
    assign last_byte    = last_reg;

endmodule

### src/websocket_frame_deframer.sv
// Path: an accepted byte waits in the input register; its result loads into the output register when it advances.
// Throughput: one byte per cycle sustained while out_ready keeps the output register free; each byte needs one
// short state update. Bytes that give no result (headers, mask key) also wait while the output register is full.
// Reset (rst_n low, asynchronous) empties both stages and returns to header parsing.
// After a close request or protocol error all further bytes are dropped until reset.
module websocket_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] payload_byte,
    output logic       last_byte
);

    // Byte held in the input register, ready for the parser.
    logic             byte_valid;
    logic [7:0]       byte_data;
    // Parser result for the held byte, before the output register.
    wsd_pkg::result_t res;
    // Output register can take a new result this cycle.
    logic             can_load;
    // Held byte moves through the parser into the output register.
    logic             advance;

    // Advance whenever a byte waits and the output side has room; a byte
    // with no result still advances, so header and key bytes stall only while the output side is full.
    assign advance = byte_valid && can_load;

    wsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .take       (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // Parser state (phase, key, key position, remaining length) updates
    // only when a byte advances, so stalls never disturb it.
    wsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance),
        .res        (res)
    );

    // Hold each result until its transfer completes on the output side.
    wsd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .res          (res),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .last_byte    (last_byte)
    );

endmodule
